// ----- src/vdt_pkg.sv -----
// Shared types and constants for the voxel dose tally.
// Used by every module of the block but vdt_ram; no dependencies.
package vdt_pkg;

    localparam int IDX_W      = 16;
    localparam int E_W        = 24;
    localparam int DENS_W     = 16;
    localparam int SUM_W      = 48;
    localparam int SQS_W      = 64;
    localparam int CNT_W      = 32;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int VOXELS_DEF = 65536;

    localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 32'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b1;

    localparam int MUL_A_W = 128;
    localparam int MUL_B_W = 64;
    localparam int MUL_P_W = 192;
    localparam int DIV_W   = 128;
    localparam int QUO_W   = 64;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEP_WR,
        S_RO_LATCH,
        S_RO_GO,
        S_MUL_DOSE,
        S_DIV_DOSE,
        S_MUL_SQ,
        S_MUL_NS2,
        S_MUL_DEN,
        S_DIV_ERR,
        S_SQRT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MO_DOSE,
        MO_SQ,
        MO_NS2,
        MO_DEN
    } t_mul_op;

    typedef enum logic [1:0] {
        MD_NONE,
        MD_SQ,
        MD_NS2
    } t_mul_dst;

    typedef struct packed {
        logic     accept;
        logic     clr_we;
        logic     dep_we;
        logic     ro_latch;
        logic     mul_start;
        t_mul_op  mul_op;
        t_mul_dst mul_dst;
        logic     div_start;
        logic     div_err;
        logic     sqrt_start;
        logic     out_fire;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic dens_zero;
        logic err_skip;
        logic ns2_le_sq;
        logic mul_done;
        logic div_done;
        logic div_ovf;
        logic sqrt_done;
    } t_sts;

endpackage

// ----- src/vdt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/vdt_mul.sv -----
// Multi-cycle multiplier, one 32x32 partial product a cycle, 128x64 bits.
// Depends on vdt_pkg.
module vdt_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vdt_pkg::MUL_A_W-1:0]  i_a,
    input  logic [vdt_pkg::MUL_B_W-1:0]  i_b,
    output logic                         o_done,
    output logic [vdt_pkg::MUL_P_W-1:0]  o_p
);

    logic                        r_busy;
    logic [2:0]                  r_k;
    logic [vdt_pkg::MUL_A_W-1:0] r_a;
    logic [vdt_pkg::MUL_B_W-1:0] r_b;
    logic [63:0]                 r_pp;
    logic [2:0]                  r_psh;
    logic                        r_ppv;
    logic                        r_pplast;
    logic [vdt_pkg::MUL_P_W-1:0] r_acc;
    logic                        r_done;

    logic [31:0]                 n_al;
    logic [31:0]                 n_bl;
    logic [vdt_pkg::MUL_P_W-1:0] n_term;

    assign n_al   = r_a[32*r_k[2:1] +: 32];
    assign n_bl   = r_b[32*r_k[0] +: 32];
    assign n_term = {128'd0, r_pp} << {r_psh, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= r_ppv & r_pplast;
            r_ppv  <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_ppv) begin
            r_acc <= r_acc + n_term;
        end
        r_pp     <= n_al * n_bl;
        r_psh    <= {1'b0, r_k[2:1]} + {2'b00, r_k[0]};
        r_pplast <= (r_k == 3'd7);
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// ----- src/vdt_div.sv -----
// Restoring divider, one quotient bit a cycle, 32- or 64-bit quotient.
// Flags overflow when the quotient does not fit. Depends on vdt_pkg.
module vdt_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_wide,
    input  logic [vdt_pkg::DIV_W-1:0]  i_x,
    input  logic [vdt_pkg::DIV_W-1:0]  i_d,
    output logic                       o_done,
    output logic                       o_ovf,
    output logic [vdt_pkg::QUO_W-1:0]  o_q
);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_ovf;
    logic [6:0]                 r_cnt;
    logic [vdt_pkg::DIV_W-1:0]  r_rem;
    logic [vdt_pkg::DIV_W-1:0]  r_xs;
    logic [vdt_pkg::DIV_W-1:0]  r_d;
    logic [vdt_pkg::QUO_W-1:0]  r_q;

    logic [vdt_pkg::DIV_W-1:0]  n_hi;
    logic                       n_ovf;
    logic [vdt_pkg::DIV_W:0]    n_t;
    logic [vdt_pkg::DIV_W:0]    n_diff;
    logic                       n_ge;

    assign n_hi   = i_wide ? {64'd0, i_x[127:64]} : {32'd0, i_x[127:32]};
    assign n_ovf  = (n_hi >= i_d);
    assign n_t    = {r_rem, r_xs[vdt_pkg::DIV_W-1]};
    assign n_diff = n_t - {1'b0, r_d};
    assign n_ge   = (n_t >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !n_ovf;
                r_done <= n_ovf;
                r_cnt  <= i_wide ? 7'd64 : 7'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= n_ovf;
            r_rem <= n_hi;
            r_xs  <= i_wide ? {i_x[63:0], 64'd0} : {i_x[31:0], 96'd0};
            r_d   <= i_d;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[vdt_pkg::DIV_W-1:0] : n_t[vdt_pkg::DIV_W-1:0];
            r_xs  <= {r_xs[vdt_pkg::DIV_W-2:0], 1'b0};
            r_q   <= {r_q[vdt_pkg::QUO_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_q    = r_q;

endmodule

// ----- src/vdt_dp.sv -----
// Datapath: voxel stores, configuration, arithmetic units and result registers.
// Depends on vdt_pkg, vdt_ram, vdt_mul and vdt_div.
module vdt_dp #(
    parameter int VOXELS = vdt_pkg::VOXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vdt_pkg::t_cmd                   i_cmd,
    output vdt_pkg::t_sts                   o_sts,
    input  logic                            i_cfg_we,
    input  logic [vdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vdt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [vdt_pkg::IDX_W-1:0]       i_voxel_index,
    input  logic [vdt_pkg::E_W-1:0]         i_energy,
    input  logic                            i_in_phantom,
    input  logic [vdt_pkg::DENS_W-1:0]      i_density,
    output logic                            o_valid,
    output logic [vdt_pkg::OUT_W-1:0]       o_dose,
    output logic [vdt_pkg::OUT_W-1:0]       o_rel_error,
    output logic                            o_status
);

    localparam int DEPTH = (VOXELS > (2 ** vdt_pkg::IDX_W)) ? (2 ** vdt_pkg::IDX_W) : VOXELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration
    logic                           r_ue;
    logic [vdt_pkg::CFG_DATA_W-1:0] r_scale;

    // transaction fields
    logic [vdt_pkg::IDX_W-1:0]  r_idx;
    logic [vdt_pkg::E_W-1:0]    r_e;
    logic [2*vdt_pkg::E_W-1:0]  r_esq;
    logic                       r_inph;
    logic [vdt_pkg::DENS_W-1:0] r_dens;

    // clearing pass
    logic [AW-1:0] r_clr;

    // readout operands and intermediates
    logic [vdt_pkg::SUM_W-1:0] r_s;
    logic [vdt_pkg::SQS_W-1:0] r_s2;
    logic [vdt_pkg::CNT_W-1:0] r_n;
    logic [95:0]               r_sq;
    logic [95:0]               r_ns2;
    logic [vdt_pkg::OUT_W-1:0] r_dose;
    logic [vdt_pkg::OUT_W-1:0] r_rel;

    // square root
    logic        r_sact;
    logic        r_sdone;
    logic [4:0]  r_sbit;
    logic [31:0] r_root;

    // result port
    logic                      r_ovalid;
    logic [vdt_pkg::OUT_W-1:0] r_odose;
    logic [vdt_pkg::OUT_W-1:0] r_orel;
    logic                      r_ostat;

    logic [vdt_pkg::SUM_W-1:0] rd_sum;
    logic [vdt_pkg::SQS_W-1:0] rd_s2;
    logic [vdt_pkg::CNT_W-1:0] rd_n;

    logic                        n_idx_ok;
    logic                        n_dep_ok;
    logic [AW-1:0]               n_waddr;
    logic [vdt_pkg::SUM_W:0]     n_sum_add;
    logic [vdt_pkg::SQS_W:0]     n_s2_add;
    logic [vdt_pkg::SUM_W-1:0]   n_wsum;
    logic [vdt_pkg::SQS_W-1:0]   n_ws2;
    logic [vdt_pkg::CNT_W-1:0]   n_wn;
    logic                        n_we_sum;
    logic                        n_we_unc;

    logic [vdt_pkg::MUL_A_W-1:0] n_ma;
    logic [vdt_pkg::MUL_B_W-1:0] n_mb;
    logic                        mul_done;
    logic [vdt_pkg::MUL_P_W-1:0] mul_p;

    logic [vdt_pkg::DIV_W-1:0]   n_dx;
    logic [vdt_pkg::DIV_W-1:0]   n_dd;
    logic                        div_done;
    logic                        div_ovf;
    logic [vdt_pkg::QUO_W-1:0]   div_q;

    logic [31:0] n_cand;
    logic [63:0] n_csq;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ue    <= 1'b0;
            r_scale <= vdt_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vdt_pkg::CFG_UE:    r_ue    <= i_cfg_data[0];
                vdt_pkg::CFG_SCALE: r_scale <= i_cfg_data;
                default:            r_ue    <= r_ue;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx  <= i_voxel_index;
            r_e    <= i_energy;
            r_esq  <= i_energy * i_energy;
            r_inph <= i_in_phantom;
            r_dens <= i_density;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // deposit read-modify-write
    assign n_idx_ok  = (32'(r_idx) < 32'(VOXELS));
    assign n_dep_ok  = i_cmd.dep_we & r_inph & n_idx_ok;
    assign n_waddr   = i_cmd.clr_we ? r_clr : r_idx[AW-1:0];
    assign n_sum_add = {1'b0, rd_sum} + (vdt_pkg::SUM_W + 1)'(r_e);
    assign n_s2_add  = {1'b0, rd_s2} + (vdt_pkg::SQS_W + 1)'(r_esq);
    assign n_we_sum  = i_cmd.clr_we | n_dep_ok;
    assign n_we_unc  = i_cmd.clr_we | (n_dep_ok & r_ue);

    always_comb begin
        if (i_cmd.clr_we) begin
            n_wsum = '0;
            n_ws2  = '0;
            n_wn   = '0;
        end else begin
            n_wsum = n_sum_add[vdt_pkg::SUM_W] ? '1 : n_sum_add[vdt_pkg::SUM_W-1:0];
            n_ws2  = n_s2_add[vdt_pkg::SQS_W] ? '1 : n_s2_add[vdt_pkg::SQS_W-1:0];
            n_wn   = (rd_n == '1) ? rd_n : rd_n + vdt_pkg::CNT_W'(1);
        end
    end

    vdt_ram #(.WIDTH(vdt_pkg::SUM_W), .DEPTH(DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (n_we_sum),
        .i_waddr (n_waddr),
        .i_wdata (n_wsum),
        .i_re    (i_cmd.accept),
        .i_raddr (i_voxel_index[AW-1:0]),
        .o_rdata (rd_sum)
    );

    vdt_ram #(.WIDTH(vdt_pkg::SQS_W), .DEPTH(DEPTH)) u_sqs_ram (
        .i_clk   (i_clk),
        .i_we    (n_we_unc),
        .i_waddr (n_waddr),
        .i_wdata (n_ws2),
        .i_re    (i_cmd.accept),
        .i_raddr (i_voxel_index[AW-1:0]),
        .o_rdata (rd_s2)
    );

    vdt_ram #(.WIDTH(vdt_pkg::CNT_W), .DEPTH(DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (n_we_unc),
        .i_waddr (n_waddr),
        .i_wdata (n_wn),
        .i_re    (i_cmd.accept),
        .i_raddr (i_voxel_index[AW-1:0]),
        .o_rdata (rd_n)
    );

    // multiplier operands
    always_comb begin
        case (i_cmd.mul_op)
            vdt_pkg::MO_DOSE: begin
                n_ma = vdt_pkg::MUL_A_W'(r_s);
                n_mb = vdt_pkg::MUL_B_W'(r_scale);
            end
            vdt_pkg::MO_SQ: begin
                n_ma = vdt_pkg::MUL_A_W'(r_s);
                n_mb = vdt_pkg::MUL_B_W'(r_s);
            end
            vdt_pkg::MO_NS2: begin
                n_ma = vdt_pkg::MUL_A_W'(r_s2);
                n_mb = vdt_pkg::MUL_B_W'(r_n);
            end
            vdt_pkg::MO_DEN: begin
                n_ma = vdt_pkg::MUL_A_W'(r_sq);
                n_mb = vdt_pkg::MUL_B_W'(r_n - vdt_pkg::CNT_W'(1));
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    vdt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (n_ma),
        .i_b     (n_mb),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // dose: S*scale / (density*256); error: ((N*S2 - S^2) << 32) / ((N-1)*S^2)
    assign n_dx = i_cmd.div_err ? {r_ns2 - r_sq, 32'd0} : mul_p[vdt_pkg::DIV_W-1:0];
    assign n_dd = i_cmd.div_err ? mul_p[vdt_pkg::DIV_W-1:0]
                                : vdt_pkg::DIV_W'({r_dens, 8'd0});

    vdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_wide  (i_cmd.div_err),
        .i_x     (n_dx),
        .i_d     (n_dd),
        .o_done  (div_done),
        .o_ovf   (div_ovf),
        .o_q     (div_q)
    );

    // integer square root of the quotient, one bit a cycle
    assign n_cand = r_root | (32'd1 << r_sbit);
    assign n_csq  = n_cand * n_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sact  <= 1'b0;
            r_sdone <= 1'b0;
            r_sbit  <= '0;
        end else begin
            r_sdone <= 1'b0;
            if (i_cmd.sqrt_start) begin
                r_sact <= 1'b1;
                r_sbit <= 5'd31;
            end else if (r_sact) begin
                r_sbit <= r_sbit - 5'd1;
                if (r_sbit == 5'd0) begin
                    r_sact  <= 1'b0;
                    r_sdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_root <= '0;
        end else if (r_sact && (n_csq <= div_q)) begin
            r_root <= n_cand;
        end
    end

    // readout registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ro_latch) begin
            r_s    <= n_idx_ok ? rd_sum : '0;
            r_s2   <= n_idx_ok ? rd_s2 : '0;
            r_n    <= n_idx_ok ? rd_n : '0;
            r_dose <= '0;
            r_rel  <= '0;
        end else begin
            if (mul_done) begin
                case (i_cmd.mul_dst)
                    vdt_pkg::MD_SQ:  r_sq  <= mul_p[95:0];
                    vdt_pkg::MD_NS2: r_ns2 <= mul_p[95:0];
                    default:         r_sq  <= r_sq;
                endcase
            end
            if (div_done) begin
                if (!i_cmd.div_err) begin
                    r_dose <= div_ovf ? '1 : div_q[vdt_pkg::OUT_W-1:0];
                end else if (div_ovf) begin
                    r_rel <= '1;
                end
            end
            if (r_sdone) begin
                r_rel <= r_root;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= i_cmd.out_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_fire) begin
            r_odose <= r_dose;
            r_orel  <= r_rel;
            r_ostat <= (r_dens == '0);
        end
    end

    assign o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
    assign o_sts.dens_zero = (r_dens == '0);
    assign o_sts.err_skip  = !r_ue || (r_n <= vdt_pkg::CNT_W'(1)) || (r_s == '0);
    assign o_sts.ns2_le_sq = (r_ns2 <= r_sq);
    assign o_sts.mul_done  = mul_done;
    assign o_sts.div_done  = div_done;
    assign o_sts.div_ovf   = div_ovf;
    assign o_sts.sqrt_done = r_sdone;

    assign o_valid     = r_ovalid;
    assign o_dose      = r_odose;
    assign o_rel_error = r_orel;
    assign o_status    = r_ostat;

endmodule

// ----- src/vdt_ctrl.sv -----
// Controller: sequences clearing, deposits and the readout arithmetic.
// Depends on vdt_pkg.
module vdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_func,
    input  vdt_pkg::t_sts i_sts,
    output vdt_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    vdt_pkg::t_state r_state;
    vdt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            vdt_pkg::S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = vdt_pkg::S_IDLE;
                end
            end
            vdt_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_func ? vdt_pkg::S_RO_LATCH : vdt_pkg::S_DEP_WR;
                end
            end
            vdt_pkg::S_DEP_WR: begin
                o_cmd.dep_we = 1'b1;
                n_state = vdt_pkg::S_IDLE;
            end
            vdt_pkg::S_RO_LATCH: begin
                o_cmd.ro_latch = 1'b1;
                n_state = vdt_pkg::S_RO_GO;
            end
            vdt_pkg::S_RO_GO: begin
                if (!i_sts.dens_zero) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = vdt_pkg::MO_DOSE;
                    n_state = vdt_pkg::S_MUL_DOSE;
                end else if (i_sts.err_skip) begin
                    n_state = vdt_pkg::S_OUT;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = vdt_pkg::MO_SQ;
                    n_state = vdt_pkg::S_MUL_SQ;
                end
            end
            vdt_pkg::S_MUL_DOSE: begin
                if (i_sts.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = vdt_pkg::S_DIV_DOSE;
                end
            end
            vdt_pkg::S_DIV_DOSE: begin
                o_cmd.mul_op = vdt_pkg::MO_SQ;
                if (i_sts.div_done) begin
                    if (i_sts.err_skip) begin
                        n_state = vdt_pkg::S_OUT;
                    end else begin
                        o_cmd.mul_start = 1'b1;
                        n_state = vdt_pkg::S_MUL_SQ;
                    end
                end
            end
            vdt_pkg::S_MUL_SQ: begin
                o_cmd.mul_dst = vdt_pkg::MD_SQ;
                o_cmd.mul_op  = vdt_pkg::MO_NS2;
                if (i_sts.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    n_state = vdt_pkg::S_MUL_NS2;
                end
            end
            vdt_pkg::S_MUL_NS2: begin
                o_cmd.mul_dst = vdt_pkg::MD_NS2;
                o_cmd.mul_op  = vdt_pkg::MO_DEN;
                if (i_sts.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    n_state = vdt_pkg::S_MUL_DEN;
                end
            end
            vdt_pkg::S_MUL_DEN: begin
                o_cmd.div_err = 1'b1;
                if (i_sts.mul_done) begin
                    if (i_sts.ns2_le_sq) begin
                        n_state = vdt_pkg::S_OUT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state = vdt_pkg::S_DIV_ERR;
                    end
                end
            end
            vdt_pkg::S_DIV_ERR: begin
                o_cmd.div_err = 1'b1;
                if (i_sts.div_done) begin
                    if (i_sts.div_ovf) begin
                        n_state = vdt_pkg::S_OUT;
                    end else begin
                        o_cmd.sqrt_start = 1'b1;
                        n_state = vdt_pkg::S_SQRT;
                    end
                end
            end
            vdt_pkg::S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = vdt_pkg::S_OUT;
                end
            end
            vdt_pkg::S_OUT: begin
                o_cmd.out_fire = 1'b1;
                n_state = vdt_pkg::S_IDLE;
            end
            default: begin
                n_state = vdt_pkg::S_IDLE;
            end
        endcase
    end

    ap_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mul_done |-> (r_state == vdt_pkg::S_MUL_DOSE || r_state == vdt_pkg::S_MUL_SQ ||
                            r_state == vdt_pkg::S_MUL_NS2 || r_state == vdt_pkg::S_MUL_DEN))
        else $error("multiplier finished outside a multiply state");

    ap_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == vdt_pkg::S_DIV_DOSE || r_state == vdt_pkg::S_DIV_ERR))
        else $error("divider finished outside a divide state");

    ap_sqrt_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.sqrt_done |-> (r_state == vdt_pkg::S_SQRT))
        else $error("square root finished outside its state");

    ap_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mul_start && o_cmd.div_start))
        else $error("multiplier and divider started together");

endmodule

// ----- src/voxel_dose_tally_with_error_core.sv -----
// Deposit: a read, then a saturating write per transaction; no result.
// Readout: at zero density with no error to form, o_valid comes via RO_LATCH, RO_GO and OUT;
// with dose and error it waits on a bit-serial divider (32- or 64-bit quotient), a bit-serial
// 32-bit square root and four multiplies on one 32x32 multiplier. One at a time.
// Reset: busy stays high for one store-clearing pass of min(VOXELS, 65536)
// cycles. o_valid lasts one cycle; the receiver cannot stall.
module voxel_dose_tally_with_error_core #(
    parameter int VOXELS = vdt_pkg::VOXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_func,
    input  logic [vdt_pkg::IDX_W-1:0]       i_voxel_index,
    input  logic [vdt_pkg::E_W-1:0]         i_energy,
    input  logic                            i_in_phantom,
    input  logic [vdt_pkg::DENS_W-1:0]      i_density,
    input  logic                            i_cfg_we,
    input  logic [vdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vdt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_valid,
    output logic [vdt_pkg::OUT_W-1:0]       o_dose,
    output logic [vdt_pkg::OUT_W-1:0]       o_rel_error,
    output logic                            o_status
);

    vdt_pkg::t_cmd cmd;
    vdt_pkg::t_sts sts;

    vdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    vdt_dp #(.VOXELS(VOXELS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_voxel_index (i_voxel_index),
        .i_energy      (i_energy),
        .i_in_phantom  (i_in_phantom),
        .i_density     (i_density),
        .o_valid       (o_valid),
        .o_dose        (o_dose),
        .o_rel_error   (o_rel_error),
        .o_status      (o_status)
    );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for voxel_dose_tally_with_error_core: directed and random deposit/readout
// transactions, checked against an in-bench tally and dose/error predictor.
// Depends on vdt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int IDX_W      = vdt_pkg::IDX_W;
    localparam int E_W        = vdt_pkg::E_W;
    localparam int DENS_W     = vdt_pkg::DENS_W;
    localparam int SUM_W      = vdt_pkg::SUM_W;
    localparam int SQS_W      = vdt_pkg::SQS_W;
    localparam int CNT_W      = vdt_pkg::CNT_W;
    localparam int OUT_W      = vdt_pkg::OUT_W;
    localparam int CFG_IDX_W  = vdt_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = vdt_pkg::CFG_DATA_W;
    localparam logic [CFG_IDX_W-1:0]  CFG_UE      = vdt_pkg::CFG_UE;
    localparam logic [CFG_IDX_W-1:0]  CFG_SCALE   = vdt_pkg::CFG_SCALE;
    localparam logic [CFG_DATA_W-1:0] SCALE_RESET = vdt_pkg::SCALE_RESET;

    localparam logic FN_DEPOSIT = 1'b0;
    localparam logic FN_READOUT = 1'b1;
    localparam logic [SUM_W-1:0] SUM_FULL = '1;
    localparam logic [SQS_W-1:0] SQS_FULL = '1;
    localparam logic [CNT_W-1:0] CNT_FULL = '1;
    localparam int SETTLE = 400;

    typedef struct {
        logic [OUT_W-1:0] dose;
        logic [OUT_W-1:0] rel_error;
        logic             status;
    } t_readout;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    logic                   i_func = 1'b0;
    logic [IDX_W-1:0]       i_voxel_index = '0;
    logic [E_W-1:0]         i_energy = '0;
    logic                   i_in_phantom = 1'b0;
    logic [DENS_W-1:0]      i_density = '0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   o_busy;
    logic                   o_valid;
    logic [OUT_W-1:0]       o_dose;
    logic [OUT_W-1:0]       o_rel_error;
    logic                   o_status;

    logic [SUM_W-1:0] sum_tally [int];
    logic [SQS_W-1:0] sqs_tally [int];
    logic [CNT_W-1:0] hit_tally [int];
    logic             model_ue;
    logic [31:0]      model_scale;
    t_readout         readouts_due [$];
    int               n_fail;
    bit               gaps_on;

    voxel_dose_tally_with_error_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [OUT_W-1:0] dose_of(logic [SUM_W-1:0] s, logic [DENS_W-1:0] d);
        logic [191:0] prod;
        logic [191:0] quo;
        if (d == 0) return '0;
        prod = 192'(s) * 192'(model_scale);
        quo  = prod / 192'({d, 8'h00});
        return (quo[191:32] != 0) ? '1 : quo[31:0];
    endfunction

    function automatic logic [OUT_W-1:0] error_of(logic [SUM_W-1:0] s, logic [SQS_W-1:0] s2,
                                                 logic [CNT_W-1:0] n);
        logic [191:0] sq, ns2, num, den, prod;
        logic [31:0]  r, c;
        r = '0;
        if (!model_ue || n <= 1 || s == 0) return '0;
        sq  = 192'(s) * 192'(s);
        ns2 = 192'(n) * 192'(s2);
        if (ns2 <= sq) return '0;
        num = (ns2 - sq) << 32;
        den = 192'(n - 1) * sq;
        for (int b = 31; b >= 0; b--) begin
            c = r | (32'd1 << b);
            prod = (192'(c) * 192'(c)) * den;
            if (prod <= num) r = c;
        end
        return r;
    endfunction

    task automatic tally_update(logic fn, int idx, logic [E_W-1:0] e, logic inph,
                                logic [DENS_W-1:0] d);
        logic [SUM_W-1:0] s;
        logic [SQS_W-1:0] s2;
        logic [CNT_W-1:0] n;
        logic [SQS_W-1:0] esq;
        t_readout         r;
        s   = sum_tally.exists(idx) ? sum_tally[idx] : '0;
        s2  = sqs_tally.exists(idx) ? sqs_tally[idx] : '0;
        n   = hit_tally.exists(idx) ? hit_tally[idx] : '0;
        esq = SQS_W'(e) * SQS_W'(e);
        if (fn == FN_DEPOSIT) begin
            if (inph) begin
                sum_tally[idx] = (s > SUM_FULL - SUM_W'(e)) ? SUM_FULL : s + SUM_W'(e);
                if (model_ue) begin
                    hit_tally[idx] = (n == CNT_FULL) ? n : n + 1;
                    sqs_tally[idx] = (s2 > SQS_FULL - esq) ? SQS_FULL : s2 + esq;
                end
            end
        end else begin
            r.dose      = dose_of(s, d);
            r.rel_error = error_of(s, s2, n);
            r.status    = (d == 0);
            readouts_due.push_back(r);
        end
    endtask

    task automatic send(logic fn, logic [IDX_W-1:0] idx, logic [E_W-1:0] e, logic inph,
                        logic [DENS_W-1:0] d);
        i_start       <= 1'b1;
        i_func        <= fn;
        i_voxel_index <= idx;
        i_energy      <= e;
        i_in_phantom  <= inph;
        i_density     <= d;
        do @(posedge i_clk); while (o_busy);
        tally_update(fn, idx, e, inph, d);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (readouts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_UE) model_ue = data[0];
        else model_scale = data;
    endtask

    always @(posedge i_clk) begin
        t_readout r;
        if (i_rst_n && o_valid) begin
            if (readouts_due.size() == 0) begin
                $error("unexpected result transaction");
                n_fail++;
            end else begin
                r = readouts_due.pop_front();
                if (o_dose !== r.dose) begin
                    $error("dose: expected %0h actual %0h", r.dose, o_dose);
                    n_fail++;
                end
                if (o_rel_error !== r.rel_error) begin
                    $error("rel_error: expected %0h actual %0h", r.rel_error, o_rel_error);
                    n_fail++;
                end
                if (o_status !== r.status) begin
                    $error("status: expected %0d actual %0d", r.status, o_status);
                    n_fail++;
                end
            end
        end
    end

    task automatic test_plain_tally;
        send(FN_READOUT, 16'd0, '0, 1'b0, 16'h0100);
        send(FN_READOUT, 16'hFFFF, '1, 1'b1, 16'h0000);
        send(FN_DEPOSIT, 16'd0, '1, 1'b1, '0);
        send(FN_DEPOSIT, 16'hFFFF, 24'd1, 1'b1, '1);
        send(FN_DEPOSIT, 16'hFFFF, '1, 1'b0, '1);
        send(FN_READOUT, 16'd0, '0, 1'b0, 16'h0001);
        send(FN_READOUT, 16'hFFFF, '0, 1'b0, 16'hFFFF);
        send(FN_READOUT, 16'd0, '0, 1'b0, 16'h0000);
    endtask

    task automatic test_scale_extremes;
        cfg_write(CFG_SCALE, 32'hFFFF_FFFF);
        send(FN_READOUT, 16'd0, '0, 1'b1, 16'h0001);
        send(FN_READOUT, 16'hFFFF, '0, 1'b1, 16'hFFFF);
        cfg_write(CFG_SCALE, 32'd1);
        send(FN_READOUT, 16'd0, '0, 1'b1, 16'h0001);
        cfg_write(CFG_SCALE, 32'd0);
        send(FN_READOUT, 16'd0, '0, 1'b1, 16'h0001);
        cfg_write(CFG_SCALE, SCALE_RESET);
    endtask

    task automatic test_uncertainty;
        cfg_write(CFG_UE, 1'b1);
        // counters inconsistent: voxel 0 summed while uncertainty was off
        send(FN_DEPOSIT, 16'd0, 24'd3, 1'b1, '0);
        send(FN_DEPOSIT, 16'd0, 24'd5, 1'b1, '0);
        send(FN_READOUT, 16'd0, '0, 1'b0, 16'h0100);
        send(FN_DEPOSIT, 16'd7, 24'd1000, 1'b1, '0);
        send(FN_READOUT, 16'd7, '0, 1'b0, 16'h0100);
        send(FN_DEPOSIT, 16'd7, 24'd1000, 1'b1, '0);
        send(FN_DEPOSIT, 16'd7, 24'd1000, 1'b1, '0);
        send(FN_READOUT, 16'd7, '0, 1'b0, 16'h0100);
        send(FN_DEPOSIT, 16'd7, 24'd1001, 1'b1, '0);
        send(FN_READOUT, 16'd7, '0, 1'b0, 16'h0000);
        send(FN_DEPOSIT, 16'd9, 24'd0, 1'b1, '0);
        send(FN_DEPOSIT, 16'd9, 24'd0, 1'b1, '0);
        send(FN_READOUT, 16'd9, '0, 1'b0, 16'h0100);
        send(FN_DEPOSIT, 16'd11, 24'd1, 1'b1, '0);
        send(FN_DEPOSIT, 16'd11, '1, 1'b1, '0);
        send(FN_READOUT, 16'd11, '0, 1'b0, 16'h0001);
    endtask

    task automatic test_random(int n_items, logic ue, logic [31:0] scale);
        logic [IDX_W-1:0]  idx;
        logic [E_W-1:0]    e;
        logic [DENS_W-1:0] d;
        cfg_write(CFG_UE, ue);
        cfg_write(CFG_SCALE, scale);
        for (int k = 0; k < n_items; k++) begin
            idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 15));
            case ($urandom_range(0, 2))
                0: e = E_W'($urandom);
                1: e = E_W'($urandom_range(0, 4095));
                default: e = E_W'(24'd500000 + $urandom_range(0, 2000));
            endcase
            d = ($urandom_range(0, 19) == 0) ? '0 : DENS_W'($urandom);
            if ($urandom_range(0, 9) < 4)
                send(FN_READOUT, idx, E_W'($urandom), 1'($urandom), d);
            else
                send(FN_DEPOSIT, idx, e, $urandom_range(0, 9) != 0, DENS_W'($urandom));
        end
    endtask

    initial begin
        n_fail      = 0;
        gaps_on     = 1'b1;
        model_ue    = 1'b0;
        model_scale = SCALE_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        test_plain_tally();
        test_scale_extremes();
        test_uncertainty();
        test_random(240, 1'b1, SCALE_RESET);
        test_random(240, 1'b0, 32'hFFFF_FFFF);
        test_random(230, 1'b1, 32'd1 + $urandom);
        gaps_on = 1'b0;
        test_random(240, 1'b1, 32'd1);
        drain();
        if (n_fail == 0)
            $display("** voxel_dose_tally_with_error_core: PASSED **");
        else
            $display("** voxel_dose_tally_with_error_core: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("** voxel_dose_tally_with_error_core: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
src/vdt_pkg.sv
src/vdt_ram.sv
src/vdt_mul.sv
src/vdt_div.sv
src/vdt_dp.sv
src/vdt_ctrl.sv
src/voxel_dose_tally_with_error_core.sv
dv/tb_top.sv
